>>> rtl/sdtq_pkg.sv
// Shared types and constants for the sorted deadline timer queue.
// No dependencies; every other file imports this package.
`default_nettype none

package sdtq_pkg;

   localparam int NUM_TIMERS = 16;
   localparam int SLOT_W     = $clog2(NUM_TIMERS);
   localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
   localparam int TIME_W     = 48;
   localparam int MAX_FIRES  = 16;
   localparam int FIRE_W     = $clog2(MAX_FIRES + 1);
   localparam int MODE_W     = 3;

   // Command codes carried in the mode field.
   typedef enum logic [MODE_W-1:0] {
      MODE_TICK    = 3'd0,
      MODE_SET_DL  = 3'd1,
      MODE_SET_PER = 3'd2,
      MODE_CLR_PER = 3'd3,
      MODE_CANCEL  = 3'd4
   } mode_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [3:0]        slot_id;
      logic [47:0]       time_value;
      logic [47:0]       now_time;
   } req_type;

   typedef struct packed {
      logic       fired_valid;
      logic [3:0] fired_slot;
      logic       last;
   } rsp_type;

   // Selects which slot addresses the deadline read port.
   typedef enum logic [1:0] {
      RD_HEAD,
      RD_POS,
      RD_SLOT
   } rd_sel_type;

   // Datapath operations, one per cycle.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_REMOVE,
      OP_SET_DL,
      OP_SET_PER,
      OP_CLR_PER,
      OP_FREE,
      OP_TAKE_HEAD,
      OP_RELOAD,
      OP_POS_INC,
      OP_INSERT,
      OP_PUSH,
      OP_EMIT_FINAL
   } op_type;

   typedef struct packed {
      op_type     op;
      rd_sel_type rd_sel;
   } cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              listed;
      logic              periodic;
      logic              fire_ok;
      logic              walk_more;
      logic              pend_valid;
      logic              out_free;
   } status_type;

endpackage

`default_nettype wire

>>> rtl/sdtq_datapath.sv
// Datapath: timer slot storage, sorted order list, walk and fire counters,
// pending fire and result register. Depends on sdtq_pkg; driven by sdtq_ctrl.
`default_nettype none

module sdtq_datapath (
   input  wire                   clock,
   input  wire                   reset,
   input  sdtq_pkg::req_type     req_data,
   input  sdtq_pkg::cmd_type     cmd,
   output sdtq_pkg::status_type  status,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output sdtq_pkg::rsp_type     rsp_data
);
   import sdtq_pkg::*;

   logic [TIME_W-1:0]     dl_ff [NUM_TIMERS];
   logic [TIME_W-1:0]     per_ff [NUM_TIMERS];
   logic [NUM_TIMERS-1:0] per_mark_ff;
   logic [NUM_TIMERS-1:0] listed_ff;
   logic [SLOT_W-1:0]     order_ff [NUM_TIMERS];
   logic [CNT_W-1:0]      cnt_ff;
   logic [CNT_W-1:0]      pos_ff;
   logic [FIRE_W-1:0]     nfire_ff;
   req_type               req_ff;
   logic [SLOT_W-1:0]     slot_ff;
   logic [TIME_W-1:0]     dnew_ff;
   logic                  pend_valid_ff;
   logic [SLOT_W-1:0]     pend_slot_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;

   logic [SLOT_W-1:0]     rd_idx;
   logic [TIME_W-1:0]     dl_rd;
   logic [TIME_W-1:0]     sat_now;
   logic [TIME_W-1:0]     sat_rl;
   logic [SLOT_W-1:0]     rm_slot;
   logic [NUM_TIMERS-1:0] match;
   logic [SLOT_W-1:0]     rm_pos;
   logic                  out_free;
   logic                  emit;

   // Saturating add of two time values.
   function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
      logic [TIME_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
   endfunction

   // Single deadline read port, addressed by list head, walk position or slot.
   always_comb begin
      case (cmd.rd_sel)
         RD_HEAD: rd_idx = order_ff[0];
         RD_POS:  rd_idx = order_ff[pos_ff[SLOT_W-1:0]];
         default: rd_idx = slot_ff;
      endcase
   end
   assign dl_rd   = dl_ff[rd_idx];
   assign sat_now = sat_add(req_ff.now_time, req_ff.time_value);
   assign sat_rl  = sat_add(dl_rd, per_ff[slot_ff]);

   // Locate the list entry to remove; a listed slot appears exactly once.
   assign rm_slot = (cmd.op == OP_TAKE_HEAD) ? order_ff[0] : slot_ff;
   always_comb begin
      rm_pos = '0;
      for (int j = 0; j < NUM_TIMERS; j++) begin
         match[j] = (CNT_W'(j) < cnt_ff) && (order_ff[j] == rm_slot);
         if (match[j]) begin
            rm_pos = rm_pos | SLOT_W'(j);
         end
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // A result is loaded by the final emit or by a push over a held fire.
   assign emit = (cmd.op == OP_EMIT_FINAL) || (cmd.op == OP_PUSH && pend_valid_ff);

   // Status toward the controller.
   always_comb begin
      status.mode       = req_ff.mode;
      status.listed     = listed_ff[slot_ff];
      status.periodic   = per_mark_ff[slot_ff];
      status.fire_ok    = (cnt_ff != '0) && (nfire_ff < FIRE_W'(MAX_FIRES))
                          && (dl_rd <= req_ff.now_time);
      status.walk_more  = (pos_ff < cnt_ff) && (dl_rd <= dnew_ff);
      status.pend_valid = pend_valid_ff;
      status.out_free   = out_free;
   end

   // Slot storage, order list and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         per_mark_ff   <= '0;
         listed_ff     <= '0;
         cnt_ff        <= '0;
         pos_ff        <= '0;
         nfire_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // The result register fills on an emit and drains when accepted.
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (out_free) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.op != OP_POS_INC) begin
            pos_ff <= '0;
         end
         case (cmd.op)
            OP_LOAD: begin
               req_ff        <= req_data;
               slot_ff       <= req_data.slot_id;
               nfire_ff      <= '0;
               pend_valid_ff <= 1'b0;
            end
            OP_REMOVE, OP_FREE, OP_TAKE_HEAD: begin
               if (cmd.op == OP_TAKE_HEAD) begin
                  slot_ff <= order_ff[0];
               end
               if (listed_ff[rm_slot]) begin
                  for (int j = 0; j < NUM_TIMERS - 1; j++) begin
                     if (SLOT_W'(j) >= rm_pos) begin
                        order_ff[j] <= order_ff[j+1];
                     end
                  end
                  cnt_ff             <= cnt_ff - 1'b1;
                  listed_ff[rm_slot] <= 1'b0;
               end
               if (cmd.op == OP_FREE) begin
                  dl_ff[slot_ff]       <= '0;
                  per_ff[slot_ff]      <= '0;
                  per_mark_ff[slot_ff] <= 1'b0;
               end
            end
            OP_SET_DL: begin
               dl_ff[slot_ff] <= req_ff.time_value;
               dnew_ff        <= req_ff.time_value;
            end
            OP_SET_PER: begin
               per_mark_ff[slot_ff] <= 1'b1;
               per_ff[slot_ff]      <= req_ff.time_value;
               if (!listed_ff[slot_ff]) begin
                  dl_ff[slot_ff] <= sat_now;
                  dnew_ff        <= sat_now;
               end
            end
            OP_CLR_PER: begin
               per_mark_ff[slot_ff] <= 1'b0;
            end
            OP_RELOAD: begin
               if (per_mark_ff[slot_ff]) begin
                  dl_ff[slot_ff] <= sat_rl;
                  dnew_ff        <= sat_rl;
               end else begin
                  dl_ff[slot_ff]  <= '0;
                  per_ff[slot_ff] <= '0;
               end
            end
            OP_POS_INC: begin
               pos_ff <= pos_ff + 1'b1;
            end
            OP_INSERT: begin
               for (int j = 1; j < NUM_TIMERS; j++) begin
                  if (CNT_W'(j) > pos_ff) begin
                     order_ff[j] <= order_ff[j-1];
                  end
               end
               order_ff[pos_ff[SLOT_W-1:0]] <= slot_ff;
               cnt_ff                       <= cnt_ff + 1'b1;
               listed_ff[slot_ff]           <= 1'b1;
            end
            OP_PUSH: begin
               // Another fire follows, so the held one is not the last.
               if (pend_valid_ff) begin
                  rsp_ff.fired_valid <= 1'b1;
                  rsp_ff.fired_slot  <= pend_slot_ff;
                  rsp_ff.last        <= 1'b0;
               end
               pend_valid_ff <= 1'b1;
               pend_slot_ff  <= slot_ff;
               nfire_ff      <= nfire_ff + 1'b1;
            end
            OP_EMIT_FINAL: begin
               rsp_ff.fired_valid <= pend_valid_ff;
               rsp_ff.fired_slot  <= pend_valid_ff ? pend_slot_ff : '0;
               rsp_ff.last        <= 1'b1;
               pend_valid_ff      <= 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The fill count always matches the number of listed slots.
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      $countones(listed_ff) == int'(cnt_ff))
      else $error("listed count out of step with listed marks");

   // An insertion never targets a full list.
   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_INSERT) |-> (cnt_ff < CNT_W'(NUM_TIMERS)))
      else $error("insert into a full order list");

   // A result is loaded only when the result register can take it.
   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_EMIT_FINAL || (cmd.op == OP_PUSH && pend_valid_ff)) |-> out_free)
      else $error("result register overwritten");

endmodule

`default_nettype wire

>>> rtl/sdtq_ctrl.sv
// Controller state machine: sequences datapath operations for each command.
// Depends on sdtq_pkg; drives sdtq_datapath through cmd_type.
`default_nettype none

module sdtq_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  sdtq_pkg::status_type status,
   output sdtq_pkg::cmd_type    cmd
);
   import sdtq_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SETDL,
      ST_WALK,
      ST_CHECK,
      ST_RELOAD,
      ST_FIRED,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;

   // Next state and operation for the current step.
   always_comb begin
      state_in   = state_ff;
      cmd.op     = OP_NONE;
      cmd.rd_sel = RD_SLOT;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (status.mode)
               MODE_TICK: state_in = ST_CHECK;
               MODE_SET_DL: begin
                  cmd.op   = OP_REMOVE;
                  state_in = ST_SETDL;
               end
               MODE_SET_PER: begin
                  cmd.op   = OP_SET_PER;
                  state_in = status.listed ? ST_DONE : ST_WALK;
               end
               MODE_CLR_PER: begin
                  cmd.op   = OP_CLR_PER;
                  state_in = ST_DONE;
               end
               MODE_CANCEL: begin
                  cmd.op   = OP_FREE;
                  state_in = ST_DONE;
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_SETDL: begin
            cmd.op   = OP_SET_DL;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            cmd.rd_sel = RD_POS;
            if (status.walk_more) begin
               cmd.op = OP_POS_INC;
            end else begin
               cmd.op   = OP_INSERT;
               state_in = (status.mode == MODE_TICK) ? ST_FIRED : ST_DONE;
            end
         end
         ST_CHECK: begin
            cmd.rd_sel = RD_HEAD;
            if (status.fire_ok) begin
               cmd.op   = OP_TAKE_HEAD;
               state_in = ST_RELOAD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_RELOAD: begin
            cmd.op   = OP_RELOAD;
            state_in = status.periodic ? ST_WALK : ST_FIRED;
         end
         ST_FIRED: begin
            if (!status.pend_valid || status.out_free) begin
               cmd.op   = OP_PUSH;
               state_in = ST_CHECK;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.op   = OP_EMIT_FINAL;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

>>> rtl/sorted_deadline_timer_queue.sv
// Top level of the sorted deadline timer queue: controller plus datapath.
// Depends on sdtq_pkg, sdtq_ctrl and sdtq_datapath.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid/req_stall    req_data (req_type)
//   rsp_      out        rsp_valid/rsp_stall    rsp_data (rsp_type)
//
// One transaction at a time. Clear period, cancel and set period on a listed
// slot go from dispatch straight to done. Set deadline removes the slot,
// writes the deadline and re-inserts it by the one-entry-per-cycle walk over
// the order list; arming set period walks the same way. A tick takes and
// reloads each due head slot, re-sorting a periodic one by the same walk.
// Reset is synchronous and empties the list. A stalled result holds its
// register; the next transaction runs until its first result and waits there.
`default_nettype none

module sorted_deadline_timer_queue (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  sdtq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output sdtq_pkg::rsp_type rsp_data
);
   import sdtq_pkg::*;

   cmd_type    cmd;
   status_type status;

   sdtq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sdtq_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
